@@ rtl/core/dll_pkg.sv @@
`default_nettype none

package dll_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int VALUE_W      = 32;

    localparam logic [2:0] OP_INSERT    = 3'd0;
    localparam logic [2:0] OP_DEL_VALUE = 3'd1;
    localparam logic [2:0] OP_DEL_FIRST = 3'd2;
    localparam logic [2:0] OP_DEL_LAST  = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS2,
        S_WALK,
        S_DF,
        S_DL1,
        S_DL2,
        S_RD1,
        S_RD2,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/dll_ram.sv @@
`default_nettype none

module dll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/doubly_linked_list_engine_core.sv @@
// states per request: insert S_INS2 if the list was not empty, delete first S_DF, delete last
// S_DL1 and S_DL2 if nodes remain, read next S_RD1 off the head and S_RD2, delete value S_WALK
// per node visited, S_OUT if the output stalls; one request at a time; the rate is set by the
// single read port of the next/value memory, one node per cycle during the delete-value walk
// synchronous active-low reset clears the sentinel links, allocation count, read cursor and
// output valid; node memories are not cleared and need no clearing pass
`default_nettype none

module doubly_linked_list_engine_core #(
    parameter int CAPACITY = dll_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // value
    input  logic [2:0]  i_s_axis_tuser,   // operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // read_value
    output logic [1:0]  o_m_axis_tuser,   // status
    output logic        o_m_axis_tlast    // read_last
);

    localparam int IW = $clog2(CAPACITY + 2);
    localparam int AW = $clog2(CAPACITY);
    localparam int VW = dll_pkg::VALUE_W;
    localparam int NW = VW + IW;

    localparam logic [IW-1:0] CAP_IX  = IW'(CAPACITY);
    localparam logic [IW-1:0] HEAD_IX = IW'(CAPACITY);
    localparam logic [IW-1:0] TAIL_IX = IW'(CAPACITY + 1);

    dll_pkg::t_state r_state, n_state;

    logic [VW-1:0] r_val, n_val;
    logic [IW-1:0] r_head_next, n_head_next;
    logic [IW-1:0] r_tail_prev, n_tail_prev;
    logic [IW-1:0] r_alloc, n_alloc;
    logic [IW-1:0] r_cursor, n_cursor;
    logic [IW-1:0] r_cur, n_cur;
    logic [IW-1:0] r_prev, n_prev;
    logic [VW-1:0] r_prev_val, n_prev_val;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_out_status, n_out_status;
    logic [VW-1:0] r_out_value, n_out_value;
    logic          r_out_last, n_out_last;
    logic [1:0]    r_res_status, n_res_status;
    logic [VW-1:0] r_res_value, n_res_value;
    logic          r_res_last, n_res_last;

    logic          fin;
    logic [1:0]    f_status;
    logic [VW-1:0] f_value;
    logic          f_last;

    logic          nm_we, nm_re;
    logic [AW-1:0] nm_waddr, nm_raddr;
    logic [NW-1:0] nm_wdata, nm_rdata;
    logic          pm_we, pm_re;
    logic [AW-1:0] pm_waddr, pm_raddr;
    logic [IW-1:0] pm_wdata, pm_rdata;

    logic [VW-1:0] d_val;
    logic [IW-1:0] d_next;
    logic [IW-1:0] rd_ix;
    logic          in_acc;
    logic          out_free;
    logic          list_empty;

    // next link and value per node
    dll_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nm_we),
        .i_waddr (nm_waddr),
        .i_wdata (nm_wdata),
        .i_re    (nm_re),
        .i_raddr (nm_raddr),
        .o_rdata (nm_rdata)
    );

    // prev link per node
    dll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_waddr),
        .i_wdata (pm_wdata),
        .i_re    (pm_re),
        .i_raddr (pm_raddr),
        .o_rdata (pm_rdata)
    );

    assign d_val      = nm_rdata[NW-1:IW];
    assign d_next     = nm_rdata[IW-1:0];
    assign rd_ix      = (d_next < CAP_IX) ? d_next : r_head_next;
    assign in_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign list_empty = !(r_head_next < CAP_IX);

    assign o_s_axis_tready = (r_state == dll_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    always_comb begin
        n_state      = r_state;
        n_val        = r_val;
        n_head_next  = r_head_next;
        n_tail_prev  = r_tail_prev;
        n_alloc      = r_alloc;
        n_cursor     = r_cursor;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_prev_val   = r_prev_val;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_res_last   = r_res_last;
        fin          = 1'b0;
        f_status     = dll_pkg::ST_OK;
        f_value      = '0;
        f_last       = 1'b0;
        nm_we        = 1'b0;
        nm_waddr     = r_cur[AW-1:0];
        nm_wdata     = {r_val, r_head_next};
        nm_re        = 1'b0;
        nm_raddr     = r_head_next[AW-1:0];
        pm_we        = 1'b0;
        pm_waddr     = r_cur[AW-1:0];
        pm_wdata     = HEAD_IX;
        pm_re        = 1'b0;
        pm_raddr     = r_tail_prev[AW-1:0];

        case (r_state)
            dll_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_val = i_s_axis_tdata;
                    case (i_s_axis_tuser)
                        dll_pkg::OP_INSERT: begin
                            if (r_alloc == CAP_IX) begin
                                f_status = dll_pkg::ST_FULL;
                                fin      = 1'b1;
                            end else begin
                                nm_we       = 1'b1;
                                nm_waddr    = r_alloc[AW-1:0];
                                nm_wdata    = {i_s_axis_tdata, r_head_next};
                                pm_we       = 1'b1;
                                pm_waddr    = r_alloc[AW-1:0];
                                pm_wdata    = HEAD_IX;
                                n_head_next = r_alloc;
                                n_alloc     = r_alloc + 1'b1;
                                n_cursor    = HEAD_IX;
                                if (r_head_next == TAIL_IX) begin
                                    n_tail_prev = r_alloc;
                                    fin         = 1'b1;
                                end else begin
                                    n_cur   = r_head_next;
                                    n_prev  = r_alloc;
                                    n_state = dll_pkg::S_INS2;
                                end
                            end
                        end
                        dll_pkg::OP_DEL_VALUE: begin
                            if (list_empty) begin
                                f_status = dll_pkg::ST_NOT_FOUND;
                                fin      = 1'b1;
                            end else begin
                                nm_re   = 1'b1;
                                n_cur   = r_head_next;
                                n_prev  = HEAD_IX;
                                n_state = dll_pkg::S_WALK;
                            end
                        end
                        dll_pkg::OP_DEL_FIRST: begin
                            if (list_empty) begin
                                f_status = dll_pkg::ST_EMPTY;
                                fin      = 1'b1;
                            end else begin
                                nm_re   = 1'b1;
                                n_state = dll_pkg::S_DF;
                            end
                        end
                        dll_pkg::OP_DEL_LAST: begin
                            if (list_empty) begin
                                f_status = dll_pkg::ST_EMPTY;
                                fin      = 1'b1;
                            end else begin
                                pm_re   = 1'b1;
                                n_state = dll_pkg::S_DL1;
                            end
                        end
                        dll_pkg::OP_READ: begin
                            if (list_empty) begin
                                f_status = dll_pkg::ST_EMPTY;
                                n_cursor = HEAD_IX;
                                fin      = 1'b1;
                            end else if (r_cursor == HEAD_IX) begin
                                nm_re   = 1'b1;
                                n_cur   = r_head_next;
                                n_state = dll_pkg::S_RD2;
                            end else begin
                                nm_re    = 1'b1;
                                nm_raddr = r_cursor[AW-1:0];
                                n_state  = dll_pkg::S_RD1;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            dll_pkg::S_INS2: begin
                pm_we    = 1'b1;
                pm_waddr = r_cur[AW-1:0];
                pm_wdata = r_prev;
                fin      = 1'b1;
            end
            dll_pkg::S_WALK: begin
                if (d_val == r_val) begin
                    if (r_prev == HEAD_IX) begin
                        n_head_next = d_next;
                    end else begin
                        nm_we    = 1'b1;
                        nm_waddr = r_prev[AW-1:0];
                        nm_wdata = {r_prev_val, d_next};
                    end
                    if (d_next == TAIL_IX) begin
                        n_tail_prev = r_prev;
                    end else begin
                        pm_we    = 1'b1;
                        pm_waddr = d_next[AW-1:0];
                        pm_wdata = r_prev;
                    end
                    n_cursor = HEAD_IX;
                    fin      = 1'b1;
                end else if (d_next < CAP_IX) begin
                    n_prev     = r_cur;
                    n_prev_val = d_val;
                    n_cur      = d_next;
                    nm_re      = 1'b1;
                    nm_raddr   = d_next[AW-1:0];
                end else begin
                    f_status = dll_pkg::ST_NOT_FOUND;
                    fin      = 1'b1;
                end
            end
            dll_pkg::S_DF: begin
                n_head_next = d_next;
                if (d_next == TAIL_IX) begin
                    n_tail_prev = HEAD_IX;
                end else begin
                    pm_we    = 1'b1;
                    pm_waddr = d_next[AW-1:0];
                    pm_wdata = HEAD_IX;
                end
                n_cursor = HEAD_IX;
                fin      = 1'b1;
            end
            dll_pkg::S_DL1: begin
                n_tail_prev = pm_rdata;
                n_cursor    = HEAD_IX;
                if (pm_rdata == HEAD_IX) begin
                    n_head_next = TAIL_IX;
                    fin         = 1'b1;
                end else begin
                    n_cur    = pm_rdata;
                    nm_re    = 1'b1;
                    nm_raddr = pm_rdata[AW-1:0];
                    n_state  = dll_pkg::S_DL2;
                end
            end
            dll_pkg::S_DL2: begin
                nm_we    = 1'b1;
                nm_waddr = r_cur[AW-1:0];
                nm_wdata = {d_val, TAIL_IX};
                fin      = 1'b1;
            end
            dll_pkg::S_RD1: begin
                n_cur    = rd_ix;
                nm_re    = 1'b1;
                nm_raddr = rd_ix[AW-1:0];
                n_state  = dll_pkg::S_RD2;
            end
            dll_pkg::S_RD2: begin
                f_value = d_val;
                if (d_next < CAP_IX) begin
                    n_cursor = r_cur;
                end else begin
                    f_last   = 1'b1;
                    n_cursor = HEAD_IX;
                end
                fin = 1'b1;
            end
            dll_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_value  = r_res_value;
                    n_out_last   = r_res_last;
                    n_state      = dll_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dll_pkg::S_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_status = f_status;
                n_out_value  = f_value;
                n_out_last   = f_last;
                n_state      = dll_pkg::S_IDLE;
            end else begin
                n_res_status = f_status;
                n_res_value  = f_value;
                n_res_last   = f_last;
                n_state      = dll_pkg::S_OUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dll_pkg::S_IDLE;
            r_head_next <= TAIL_IX;
            r_tail_prev <= HEAD_IX;
            r_alloc     <= '0;
            r_cursor    <= HEAD_IX;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head_next <= n_head_next;
            r_tail_prev <= n_tail_prev;
            r_alloc     <= n_alloc;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val        <= n_val;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_prev_val   <= n_prev_val;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_res_last   <= n_res_last;
    end

    a_alloc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alloc <= CAP_IX)
        else $error("allocation count beyond capacity");

    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_s_axis_tuser == dll_pkg::OP_INSERT) && (r_alloc != CAP_IX)
        |=> r_alloc == $past(r_alloc) + 1'b1)
        else $error("insert did not advance allocation");

    a_sentinels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dll_pkg::S_IDLE) |-> ((r_head_next == TAIL_IX) == (r_tail_prev == HEAD_IX)))
        else $error("sentinel links disagree on empty list");

    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_status == dll_pkg::ST_OK)
        else $error("last flag on failed result");

endmodule

`default_nettype wire
